// ----- hdl/acv_pkg.sv -----
// acv_pkg: shared types and constants of the allocation chain validator
// used by acv_ctrl, acv_dpath and allocation_chain_validator; no dependencies

package acv_pkg;

	localparam int CFG_W  = 13;
	localparam int LINK_W = 32;

	localparam logic [LINK_W-1:0] LINK_END  = 32'hFFFF_FFFE;
	localparam logic [LINK_W-1:0] LINK_FREE = 32'hFFFF_FFFF;

	localparam logic [CFG_W-1:0] USED_RESET  = 13'd0;
	localparam logic [CFG_W-1:0] LIMIT_RESET = 13'd4096;

	typedef enum logic {
		REG_USED_COUNT  = 1'b0,
		REG_CHAIN_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_OK            = 4'd0,
		ST_UNDERCOVER    = 4'd1,
		ST_OUT_OF_RANGE  = 4'd2,
		ST_REFS_FREE     = 4'd3,
		ST_SHARED        = 4'd4,
		ST_TAIL_NOT_FREE = 4'd5,
		ST_CYCLE         = 4'd6,
		ST_TOO_LONG      = 4'd7,
		ST_CAPACITY      = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		VM_NEW     = 2'd0,
		VM_ON_PATH = 2'd1,
		VM_DONE    = 2'd2
	} visit_mark_t;

	typedef enum logic [1:0] {
		LS_IDX,
		LS_LINK,
		LS_CUR
	} link_sel_t;

	typedef enum logic [1:0] {
		VOP_NONE,
		VOP_CUR_DONE,
		VOP_CUR_ON,
		VOP_UNWIND
	} visit_op_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_LOAD,
		S_CHECK,
		S_PRED_RD,
		S_PRED_EV,
		S_PRED_EV2,
		S_TAIL_RD,
		S_TAIL_EV,
		S_WALK_START,
		S_WALK_STCHK,
		S_WALK_RD,
		S_WALK_EV,
		S_UNWIND_RD,
		S_UNWIND_WR,
		S_DONE
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic        load;
		logic        clr_step;
		logic        clr_finish;
		logic        idx_zero;
		logic        idx_to_used;
		logic        idx_inc;
		link_sel_t   link_sel;
		logic        visit_rd_cur;
		logic        e_latch;
		logic        pred_set;
		visit_op_t   visit_op;
		logic        cur_from_idx;
		logic        cur_from_next;
		logic        depth_zero;
		logic        push;
		logic        k_zero;
		logic        k_inc;
		logic        code_wr;
		status_t     code;
		logic        out_load;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic overflow;
		logic undercover;
		logic idx_at_used;
		logic idx_at_loaded;
		logic link_free;
		logic link_end;
		logic link_oor;
		logic pred_set;
		logic visit_nz;
		logic visit_on_path;
		logic visit_done;
		logic depth_at_limit;
		logic k_at_depth;
		logic clr_done;
		logic out_free;
	} st_t;

endpackage

// ----- hdl/acv_ctrl.sv -----
// acv_ctrl: sequencer of the allocation chain validator
// drives acv_dpath through acv_pkg::cmd_t and reads its acv_pkg::st_t status

module acv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          is_last,
	output logic          in_stall,
	input  acv_pkg::st_t  st,
	output acv_pkg::cmd_t cmd
);

	acv_pkg::state_t state_q;
	acv_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acv_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			acv_pkg::S_CLEAR: begin
				if (st.clr_done) state_d = acv_pkg::S_LOAD;
			end
			acv_pkg::S_LOAD: begin
				if (in_valid && is_last) state_d = acv_pkg::S_CHECK;
			end
			acv_pkg::S_CHECK: begin
				if (st.overflow || st.undercover) state_d = acv_pkg::S_DONE;
				else state_d = acv_pkg::S_PRED_RD;
			end
			acv_pkg::S_PRED_RD: begin
				if (st.idx_at_used) state_d = acv_pkg::S_TAIL_RD;
				else state_d = acv_pkg::S_PRED_EV;
			end
			acv_pkg::S_PRED_EV: begin
				if (st.link_free || st.link_end) state_d = acv_pkg::S_PRED_RD;
				else if (st.link_oor) state_d = acv_pkg::S_DONE;
				else state_d = acv_pkg::S_PRED_EV2;
			end
			acv_pkg::S_PRED_EV2: begin
				if (st.link_free || st.pred_set) state_d = acv_pkg::S_DONE;
				else state_d = acv_pkg::S_PRED_RD;
			end
			acv_pkg::S_TAIL_RD: begin
				if (st.idx_at_loaded) state_d = acv_pkg::S_WALK_START;
				else state_d = acv_pkg::S_TAIL_EV;
			end
			acv_pkg::S_TAIL_EV: begin
				if (!st.link_free) state_d = acv_pkg::S_DONE;
				else state_d = acv_pkg::S_TAIL_RD;
			end
			acv_pkg::S_WALK_START: begin
				if (st.idx_at_used) state_d = acv_pkg::S_DONE;
				else state_d = acv_pkg::S_WALK_STCHK;
			end
			acv_pkg::S_WALK_STCHK: begin
				if (st.visit_nz) state_d = acv_pkg::S_WALK_START;
				else state_d = acv_pkg::S_WALK_RD;
			end
			acv_pkg::S_WALK_RD: begin
				state_d = acv_pkg::S_WALK_EV;
			end
			acv_pkg::S_WALK_EV: begin
				if (st.visit_on_path) state_d = acv_pkg::S_DONE;
				else if (st.visit_done || st.link_free) state_d = acv_pkg::S_UNWIND_RD;
				else if (st.depth_at_limit) state_d = acv_pkg::S_DONE;
				else if (st.link_end || st.link_oor) state_d = acv_pkg::S_UNWIND_RD;
				else state_d = acv_pkg::S_WALK_RD;
			end
			acv_pkg::S_UNWIND_RD: begin
				if (st.k_at_depth) state_d = acv_pkg::S_WALK_START;
				else state_d = acv_pkg::S_UNWIND_WR;
			end
			acv_pkg::S_UNWIND_WR: begin
				state_d = acv_pkg::S_UNWIND_RD;
			end
			acv_pkg::S_DONE: begin
				if (st.out_free) state_d = acv_pkg::S_CLEAR;
			end
			default: begin
				state_d = acv_pkg::S_CLEAR;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		cmd.code = acv_pkg::ST_OK;
		in_stall = 1'b1;
		case (state_q)
			acv_pkg::S_CLEAR: begin
				if (st.clr_done) cmd.clr_finish = 1'b1;
				else cmd.clr_step = 1'b1;
			end
			acv_pkg::S_LOAD: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			acv_pkg::S_CHECK: begin
				cmd.idx_zero = 1'b1;
				if (st.overflow) begin
					cmd.code_wr = 1'b1;
					cmd.code    = acv_pkg::ST_CAPACITY;
				end else if (st.undercover) begin
					cmd.code_wr = 1'b1;
					cmd.code    = acv_pkg::ST_UNDERCOVER;
				end
			end
			acv_pkg::S_PRED_RD: begin
				cmd.link_sel = acv_pkg::LS_IDX;
				if (st.idx_at_used) cmd.idx_to_used = 1'b1;
			end
			acv_pkg::S_PRED_EV: begin
				// follow the link: read its target and the target's predecessor bit
				cmd.link_sel = acv_pkg::LS_LINK;
				cmd.e_latch  = 1'b1;
				if (st.link_free || st.link_end) begin
					cmd.idx_inc = 1'b1;
				end else if (st.link_oor) begin
					cmd.code_wr = 1'b1;
					cmd.code    = acv_pkg::ST_OUT_OF_RANGE;
				end
			end
			acv_pkg::S_PRED_EV2: begin
				if (st.link_free) begin
					cmd.code_wr = 1'b1;
					cmd.code    = acv_pkg::ST_REFS_FREE;
				end else if (st.pred_set) begin
					cmd.code_wr = 1'b1;
					cmd.code    = acv_pkg::ST_SHARED;
				end else begin
					cmd.pred_set = 1'b1;
					cmd.idx_inc  = 1'b1;
				end
			end
			acv_pkg::S_TAIL_RD: begin
				cmd.link_sel = acv_pkg::LS_IDX;
				if (st.idx_at_loaded) cmd.idx_zero = 1'b1;
			end
			acv_pkg::S_TAIL_EV: begin
				if (!st.link_free) begin
					cmd.code_wr = 1'b1;
					cmd.code    = acv_pkg::ST_TAIL_NOT_FREE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			acv_pkg::S_WALK_START: begin
				cmd.visit_rd_cur = 1'b0;
				if (st.idx_at_used) begin
					cmd.code_wr = 1'b1;
					cmd.code    = acv_pkg::ST_OK;
				end
			end
			acv_pkg::S_WALK_STCHK: begin
				if (st.visit_nz) begin
					cmd.idx_inc = 1'b1;
				end else begin
					cmd.cur_from_idx = 1'b1;
					cmd.depth_zero   = 1'b1;
				end
			end
			acv_pkg::S_WALK_RD: begin
				cmd.link_sel     = acv_pkg::LS_CUR;
				cmd.visit_rd_cur = 1'b1;
			end
			acv_pkg::S_WALK_EV: begin
				cmd.k_zero = 1'b1;
				if (st.visit_on_path) begin
					cmd.code_wr = 1'b1;
					cmd.code    = acv_pkg::ST_CYCLE;
				end else if (st.visit_done) begin
					cmd.k_zero = 1'b1;
				end else if (st.link_free) begin
					cmd.visit_op = acv_pkg::VOP_CUR_DONE;
				end else if (st.depth_at_limit) begin
					cmd.code_wr = 1'b1;
					cmd.code    = acv_pkg::ST_TOO_LONG;
				end else begin
					cmd.visit_op = acv_pkg::VOP_CUR_ON;
					cmd.push     = 1'b1;
					if (!(st.link_end || st.link_oor)) cmd.cur_from_next = 1'b1;
				end
			end
			acv_pkg::S_UNWIND_RD: begin
				if (st.k_at_depth) cmd.idx_inc = 1'b1;
			end
			acv_pkg::S_UNWIND_WR: begin
				cmd.visit_op = acv_pkg::VOP_UNWIND;
				cmd.k_inc    = 1'b1;
			end
			acv_pkg::S_DONE: begin
				cmd.out_load = st.out_free;
			end
			default: begin
				cmd.code = acv_pkg::ST_OK;
			end
		endcase
	end

endmodule

// ----- hdl/acv_dpath.sv -----
// acv_dpath: table, predecessor, visit and path memories, counters,
// configuration registers and output register; types from acv_pkg

module acv_dpath #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_index,
	input  logic [acv_pkg::CFG_W-1:0]       cfg_data,
	input  logic [acv_pkg::LINK_W-1:0]      link_value,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [3:0]                      status_code,
	input  acv_pkg::cmd_t                   cmd,
	output acv_pkg::st_t                    st
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int MW = (CW > acv_pkg::CFG_W) ? CW : acv_pkg::CFG_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic [acv_pkg::CFG_W-1:0] used_q;
	logic [acv_pkg::CFG_W-1:0] limit_q;
	logic [CW-1:0]             loaded_q;
	logic                      ovf_q;
	logic                      clr_all_q;
	logic [CW-1:0]             clr_q;
	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             depth_q;
	logic [CW-1:0]             k_q;
	logic [AW-1:0]             cur_q;
	logic [AW-1:0]             e_q;
	acv_pkg::status_t          code_q;
	logic                      out_valid_q;
	acv_pkg::status_t          out_code_q;

	logic [acv_pkg::LINK_W-1:0] link_mem [TABLE_DEPTH];
	logic [acv_pkg::LINK_W-1:0] link_rd_q;
	logic                       pred_mem [TABLE_DEPTH];
	logic                       pred_rd_q;
	acv_pkg::visit_mark_t       visit_mem [TABLE_DEPTH];
	acv_pkg::visit_mark_t       visit_rd_q;
	logic [AW-1:0]              path_mem [TABLE_DEPTH];
	logic [AW-1:0]              path_rd_q;

	logic [MW-1:0]              used_m;
	logic [CW-1:0]              used_c;
	logic [CW-1:0]              clr_lim;
	logic                       store_ok;
	logic [AW-1:0]              link_ra;
	logic [AW-1:0]              visit_ra;
	logic                       visit_we;
	logic [AW-1:0]              visit_wa;
	acv_pkg::visit_mark_t       visit_wd;
	logic                       pred_we;
	logic [AW-1:0]              pred_wa;

	assign used_m   = MW'(used_q);
	assign used_c   = used_m[CW-1:0];
	assign clr_lim  = clr_all_q ? DEPTH_C : loaded_q;
	assign store_ok = (loaded_q != DEPTH_C);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= acv_pkg::USED_RESET;
			limit_q <= acv_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			case (acv_pkg::reg_idx_t'(cfg_index))
				acv_pkg::REG_USED_COUNT:  used_q  <= cfg_data;
				acv_pkg::REG_CHAIN_LIMIT: limit_q <= cfg_data;
				default: used_q <= used_q;
			endcase
		end
	end

	// load counter, clear sweep and walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= '0;
			ovf_q     <= 1'b0;
			clr_all_q <= 1'b1;
			clr_q     <= '0;
			idx_q     <= '0;
			depth_q   <= '0;
			k_q       <= '0;
		end else begin
			if (cmd.clr_finish) begin
				loaded_q  <= '0;
				ovf_q     <= 1'b0;
				clr_all_q <= 1'b0;
				clr_q     <= '0;
			end else begin
				if (cmd.load) begin
					if (store_ok) loaded_q <= loaded_q + 1'b1;
					else ovf_q <= 1'b1;
				end
				if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			end

			if (cmd.idx_zero) idx_q <= '0;
			else if (cmd.idx_to_used) idx_q <= used_c;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;

			if (cmd.depth_zero) depth_q <= '0;
			else if (cmd.push) depth_q <= depth_q + 1'b1;

			if (cmd.k_zero) k_q <= '0;
			else if (cmd.k_inc) k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cur_from_idx) cur_q <= idx_q[AW-1:0];
		else if (cmd.cur_from_next) cur_q <= link_rd_q[AW-1:0];
		if (cmd.e_latch) e_q <= link_rd_q[AW-1:0];
		if (cmd.code_wr) code_q <= cmd.code;
	end

	// link table
	always_comb begin
		case (cmd.link_sel)
			acv_pkg::LS_IDX:  link_ra = idx_q[AW-1:0];
			acv_pkg::LS_LINK: link_ra = link_rd_q[AW-1:0];
			acv_pkg::LS_CUR:  link_ra = cur_q;
			default:          link_ra = idx_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load && store_ok) link_mem[loaded_q[AW-1:0]] <= link_value;
		link_rd_q <= link_mem[link_ra];
	end

	// predecessor bits, read at the target of the link just fetched
	assign pred_we = cmd.clr_step || cmd.pred_set;
	assign pred_wa = cmd.clr_step ? clr_q[AW-1:0] : e_q;

	always_ff @(posedge clk) begin
		if (pred_we) pred_mem[pred_wa] <= !cmd.clr_step;
		pred_rd_q <= pred_mem[link_rd_q[AW-1:0]];
	end

	// visit marks
	assign visit_ra = cmd.visit_rd_cur ? cur_q : idx_q[AW-1:0];

	always_comb begin
		visit_we = 1'b1;
		visit_wa = cur_q;
		visit_wd = acv_pkg::VM_DONE;
		if (cmd.clr_step) begin
			visit_wa = clr_q[AW-1:0];
			visit_wd = acv_pkg::VM_NEW;
		end else begin
			case (cmd.visit_op)
				acv_pkg::VOP_CUR_DONE: visit_wd = acv_pkg::VM_DONE;
				acv_pkg::VOP_CUR_ON:   visit_wd = acv_pkg::VM_ON_PATH;
				acv_pkg::VOP_UNWIND:   visit_wa = path_rd_q;
				default:               visit_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (visit_we) visit_mem[visit_wa] <= visit_wd;
		visit_rd_q <= visit_mem[visit_ra];
	end

	// path of the chain being walked
	always_ff @(posedge clk) begin
		if (cmd.push) path_mem[depth_q[AW-1:0]] <= cur_q;
		path_rd_q <= path_mem[k_q[AW-1:0]];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) out_code_q <= code_q;
	end

	assign out_valid   = out_valid_q;
	assign status_code = out_code_q;

	// status
	always_comb begin
		st.overflow       = ovf_q;
		st.undercover     = used_m > MW'(loaded_q);
		st.idx_at_used    = (idx_q == used_c);
		st.idx_at_loaded  = (idx_q == loaded_q);
		st.link_free      = (link_rd_q == acv_pkg::LINK_FREE);
		st.link_end       = (link_rd_q == acv_pkg::LINK_END);
		st.link_oor       = (link_rd_q >= acv_pkg::LINK_W'(used_q));
		st.pred_set       = pred_rd_q;
		st.visit_nz       = (visit_rd_q != acv_pkg::VM_NEW);
		st.visit_on_path  = (visit_rd_q == acv_pkg::VM_ON_PATH);
		st.visit_done     = (visit_rd_q == acv_pkg::VM_DONE);
		st.depth_at_limit = (MW'(depth_q) >= MW'(limit_q));
		st.k_at_depth     = (k_q == depth_q);
		st.clr_done       = (clr_q == clr_lim);
		st.out_free       = !out_valid_q || !out_stall;
	end

endmodule

// ----- hdl/allocation_chain_validator.sv -----
// allocation_chain_validator: top level, joins the sequencer and the datapath
// depends on acv_pkg, acv_ctrl and acv_dpath

// Loads a table of next-entry links one entry per cycle; the transaction with
// is_last closes the table and, after validation, yields one status_code.
// Validation reads the table, predecessor, visit and path memories in turn: a
// link and predecessor pass over the used entries, a free-tail pass over the
// entries from used_count up to the loaded count, and a chain walk from each
// start entry that marks the entries of each chain and later retires them
// through the path store. After each status is loaded into the output
// register a sweep over the loaded entries clears the predecessor and visit
// marks; after reset that sweep covers all TABLE_DEPTH entries. No entry is
// taken during validation or sweeps; configuration writes are always taken.
// Entries beyond TABLE_DEPTH are dropped and the table answers with the
// capacity status.

module allocation_chain_validator #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [acv_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [acv_pkg::LINK_W-1:0]   link_value,
	input  logic                         is_last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [3:0]                   status_code
);

	acv_pkg::cmd_t cmd;
	acv_pkg::st_t  st;

	assign cfg_ready = 1'b1;

	acv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.is_last  (is_last),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	acv_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.link_value  (link_value),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status_code (status_code),
		.cmd         (cmd),
		.st          (st)
	);

endmodule
